// ===== rtl/ajo_pkg.sv =====
package ajo_pkg;

  // Field widths.
  localparam int unsigned RegW    = 31;
  localparam int unsigned OffW    = 32;
  localparam int unsigned CfgIdxW = 3;

  // Reset values of the configuration registers.
  localparam logic [RegW-1:0] LimitXRst   = 31'd1048576;
  localparam logic [RegW-1:0] LimitYRst   = 31'd1048576;
  localparam logic [RegW-1:0] StepInitRst = 31'd4096;
  localparam logic [RegW-1:0] StepIncRst  = 31'd1024;
  localparam logic [RegW-1:0] StepCeilRst = 31'd65536;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_LIMIT_X   = 3'd0,
    CFG_LIMIT_Y   = 3'd1,
    CFG_STEP_INIT = 3'd2,
    CFG_STEP_INC  = 3'd3,
    CFG_STEP_CEIL = 3'd4
  } ajo_cfg_idx_e;

  // One result beat: the offset pair.
  typedef struct packed {
    logic signed [OffW-1:0] offset_x;
    logic signed [OffW-1:0] offset_y;
  } ajo_result_t;

  // Move toward negative values and clamp at minus the limit.
  function automatic logic signed [OffW-1:0] move_neg(
    input logic signed [OffW-1:0] v,
    input logic        [RegW-1:0] s,
    input logic        [RegW-1:0] lim
  );
    logic signed [OffW+1:0] w;
    logic signed [OffW+1:0] lo;
    w  = {{2{v[OffW-1]}}, v} - $signed({3'b000, s});
    lo = -$signed({3'b000, lim});
    if (w < lo) begin
      w = lo;
    end
    return w[OffW-1:0];
  endfunction

  // Move toward positive values and clamp at the limit.
  function automatic logic signed [OffW-1:0] move_pos(
    input logic signed [OffW-1:0] v,
    input logic        [RegW-1:0] s,
    input logic        [RegW-1:0] lim
  );
    logic signed [OffW+1:0] w;
    logic signed [OffW+1:0] hi;
    w  = {{2{v[OffW-1]}}, v} + $signed({3'b000, s});
    hi = $signed({3'b000, lim});
    if (w > hi) begin
      w = hi;
    end
    return w[OffW-1:0];
  endfunction

  // Grow a held step and cap it at the ceiling.
  function automatic logic [RegW-1:0] grow_step(
    input logic [RegW-1:0] s,
    input logic [RegW-1:0] inc,
    input logic [RegW-1:0] ceil
  );
    logic [RegW:0] w;
    w = {1'b0, s} + {1'b0, inc};
    if (w > {1'b0, ceil}) begin
      return ceil;
    end
    return w[RegW-1:0];
  endfunction

endpackage

// ===== rtl/accelerating_two_axis_jog_offset.sv =====
// Two-axis jog offset with accelerating button steps. Each accepted beat is either a
// button tick or a recenter; every beat yields one result beat carrying the new signed
// 16.16 horizontal and vertical offsets. A held button moves its axis by its own step,
// clamped at the limit on the side it moves toward, and the step then grows by the
// increment up to the ceiling; a released button's step returns to the initial value.
// Up is applied before down and left before right. The block takes one beat per clock
// cycle while in_stall_o is low; each result goes to the result register, or to the
// skid register while the output stalls. A two-entry output stage (result
// register plus skid register) keeps input acceptance going while a result waits.
// Configuration writes are always ready and take effect on the next beat.
module accelerating_two_axis_jog_offset (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write channel.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ajo_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [ajo_pkg::RegW-1:0]            cfg_data_i,
  // Input channel.
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                cmd_i,
  input  logic                                up_held_i,
  input  logic                                down_held_i,
  input  logic                                left_held_i,
  input  logic                                right_held_i,
  // Output channel.
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [ajo_pkg::OffW-1:0]     offset_x_out_o,
  output logic signed [ajo_pkg::OffW-1:0]     offset_y_out_o
);
  import ajo_pkg::*;

  logic [RegW-1:0] limit_x_q, limit_y_q, step_init_q, step_inc_q, step_ceil_q;

  logic signed [OffW-1:0] off_x_q, off_x_d, off_y_q, off_y_d;
  logic [RegW-1:0] step_up_q, step_up_d, step_dn_q, step_dn_d;
  logic [RegW-1:0] step_lt_q, step_lt_d, step_rt_q, step_rt_d;
  logic signed [OffW-1:0] y_mid, x_mid;

  ajo_result_t out_q, skid_q, res;
  logic        out_valid_q, skid_valid_q;
  logic        in_acc, out_free;

  // Configuration registers; writes are never held off.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_x_q   <= LimitXRst;
      limit_y_q   <= LimitYRst;
      step_init_q <= StepInitRst;
      step_inc_q  <= StepIncRst;
      step_ceil_q <= StepCeilRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_LIMIT_X:   limit_x_q   <= cfg_data_i;
        CFG_LIMIT_Y:   limit_y_q   <= cfg_data_i;
        CFG_STEP_INIT: step_init_q <= cfg_data_i;
        CFG_STEP_INC:  step_inc_q  <= cfg_data_i;
        CFG_STEP_CEIL: step_ceil_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshakes: the input stalls only when the skid register is occupied.
  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i && !skid_valid_q;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Offset and step update for one beat.
  always_comb begin
    y_mid = up_held_i   ? move_neg(off_y_q, step_up_q, limit_y_q) : off_y_q;
    x_mid = left_held_i ? move_neg(off_x_q, step_lt_q, limit_x_q) : off_x_q;
    if (cmd_i) begin
      off_x_d   = '0;
      off_y_d   = '0;
      step_up_d = step_init_q;
      step_dn_d = step_init_q;
      step_lt_d = step_init_q;
      step_rt_d = step_init_q;
    end else begin
      off_y_d   = down_held_i  ? move_pos(y_mid, step_dn_q, limit_y_q) : y_mid;
      off_x_d   = right_held_i ? move_pos(x_mid, step_rt_q, limit_x_q) : x_mid;
      step_up_d = up_held_i    ? grow_step(step_up_q, step_inc_q, step_ceil_q) : step_init_q;
      step_dn_d = down_held_i  ? grow_step(step_dn_q, step_inc_q, step_ceil_q) : step_init_q;
      step_lt_d = left_held_i  ? grow_step(step_lt_q, step_inc_q, step_ceil_q) : step_init_q;
      step_rt_d = right_held_i ? grow_step(step_rt_q, step_inc_q, step_ceil_q) : step_init_q;
    end
    res.offset_x = off_x_d;
    res.offset_y = off_y_d;
  end

  // State registers advance on every accepted beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_x_q   <= '0;
      off_y_q   <= '0;
      step_up_q <= StepInitRst;
      step_dn_q <= StepInitRst;
      step_lt_q <= StepInitRst;
      step_rt_q <= StepInitRst;
    end else if (in_acc) begin
      off_x_q   <= off_x_d;
      off_y_q   <= off_y_d;
      step_up_q <= step_up_d;
      step_dn_q <= step_dn_d;
      step_lt_q <= step_lt_d;
      step_rt_q <= step_rt_d;
    end
  end

  // Output stage control: result register backed by a skid register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Output stage payload.
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_acc) begin
        out_q <= res;
      end
    end else if (in_acc) begin
      skid_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign offset_x_out_o = out_q.offset_x;
  assign offset_y_out_o = out_q.offset_y;

endmodule
